// ===== sv/sit_pkg.sv =====
package sit_pkg;

    localparam int SET_CAPACITY_DEF = 16;
    localparam int VALUE_W          = 32;
    localparam int KIND_W           = 2;
    localparam int COUNT_OUT_W      = 5;
    localparam int M_TDATA_W        = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_TEST   = 2'd2
    } kind_t;

    // Search token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic               vld;
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic [VALUE_W-1:0] last;
    } token_t;

    // Write-back command broadcast to every cell when the token leaves the chain.
    typedef struct packed {
        logic               wr_new;
        logic               wr_move;
        logic [VALUE_W-1:0] data;
    } wb_t;

endpackage

// ===== sv/sit_cell.sv =====
module sit_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            held,
    input  logic            is_last,
    input  logic            is_next,
    input  sit_pkg::wb_t    wb,
    input  sit_pkg::token_t tok_in,
    output sit_pkg::token_t tok_out,
    output logic            matched
);
    import sit_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               matched_reg;
    logic               matched_next;
    logic               hit_here;

    // An entry at or above the count is never compared, since it may be stale.
    assign hit_here = tok_in.vld && held && (entry_reg == tok_in.value);

    always_comb begin
        tok_next     = tok_in;
        matched_next = matched_reg;
        if (tok_in.vld) begin
            matched_next = hit_here;
            if (hit_here) begin
                tok_next.hit = 1'b1;
            end
            if (is_last) begin
                tok_next.last = entry_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
            matched_reg <= 1'b0;
        end else begin
            tok_reg.vld <= tok_next.vld;
            matched_reg <= matched_next;
        end
        tok_reg.kind  <= tok_next.kind;
        tok_reg.value <= tok_next.value;
        tok_reg.hit   <= tok_next.hit;
        tok_reg.last  <= tok_next.last;
    end

    // A remove refills the matching slot with the last entry; an add fills the
    // first free slot.
    always_ff @(posedge aclk) begin
        if (wb.wr_move && matched_reg) begin
            entry_reg <= wb.data;
        end else if (wb.wr_new && is_next) begin
            entry_reg <= wb.data;
        end
    end

    assign tok_out = tok_reg;
    assign matched = matched_reg;

endmodule

// ===== sv/small_integer_set_table.sv =====
// Set of distinct 32-bit values held in a row of SET_CAPACITY cells, one entry
// per cell. An operation (add, remove or test, given in s_tuser) enters the first
// cell and moves one cell per clock, comparing against each held entry and
// picking up the last held entry on its way. When it leaves the last cell the
// store and count are updated and the result is registered. The next item is
// taken once the search has left the chain and the result register is free,
// at the earliest in the cycle in which the previous result is transferred.
// Only one item is in the chain at a time. An add of a new value into a full
// set is dropped and flagged; entry_count is the count taken modulo 32.
module small_integer_set_table #(
    parameter int SET_CAPACITY = sit_pkg::SET_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sit_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value (signed)
    input  logic [sit_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sit_pkg::M_TDATA_W-1:0] m_tdata    // [0] was_present, [5:1] entry_count,
                                                     // [6] full_drop, [7] zero
);
    import sit_pkg::*;

    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAPACITY);

    logic                 busy_reg;
    logic                 busy_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    token_t                  tok_chain [0:SET_CAPACITY];
    logic [SET_CAPACITY-1:0] matched_vec;
    wb_t                     wb;
    token_t                  tok_done;
    logic                    s_accept;
    logic                    drop;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        tok_chain[0].vld   = s_accept;
        tok_chain[0].kind  = kind_t'(s_tuser);
        tok_chain[0].value = s_tdata;
        tok_chain[0].hit   = 1'b0;
        tok_chain[0].last  = '0;
    end

    for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
        localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);
        sit_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .held    (IDX < count_reg),
            .is_last (IDX1 == count_reg),
            .is_next (IDX == count_reg),
            .wb      (wb),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .matched (matched_vec[i])
        );
    end

    assign tok_done = tok_chain[SET_CAPACITY];

    always_comb begin
        wb.wr_new     = 1'b0;
        wb.wr_move    = 1'b0;
        wb.data       = tok_done.value;
        count_next    = count_reg;
        drop          = 1'b0;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        count_wide    = '0;
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (tok_done.vld) begin
            case (tok_done.kind)
                KIND_ADD: begin
                    if (!tok_done.hit) begin
                        if (count_reg == CAP) begin
                            drop = 1'b1;
                        end else begin
                            wb.wr_new  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                KIND_REMOVE: begin
                    if (tok_done.hit) begin
                        wb.wr_move = 1'b1;
                        wb.data    = tok_done.last;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
            count_wide    = (CNT_W + COUNT_OUT_W)'(count_next);
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, drop, count_wide[COUNT_OUT_W-1:0], tok_done.hit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A token only leaves the chain for an accepted item.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_done.vld |-> busy_reg)
        else $error("token left the chain with no item in flight");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("entry count above capacity");

    // No duplicates are held, so once a search has passed every cell at most
    // one cell has matched. Cells not yet reached still show the previous search.
    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_done.vld |-> $onehot0(matched_vec))
        else $error("value matched in more than one cell");

    a_drop_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[6]) |-> !m_tdata_reg[0])
        else $error("dropped add reported a present value");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(tok_done.vld))
        else $error("result raised without a finished search");

endmodule

// ===== bench/small_integer_set_table_tb.sv =====
`timescale 1ns / 100ps

module small_integer_set_table_tb;
    import sit_pkg::*;

    localparam int         CAPACITY      = SET_CAPACITY_DEF;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 2 * (CAPACITY + 1) + 16;
    localparam int         MAX_REPORTS   = 60;

    typedef struct packed {
        logic       was_present;
        logic [4:0] entry_count;
        logic       full_drop;
    } set_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata  = '0;
    logic [KIND_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Shadow copy of the set and the results still owed by the block.
    logic [31:0]   set_store [CAPACITY];
    int            set_count;
    set_result_t   pending_results [$];

    logic [31:0]   value_pool [32];
    int            pool_size;
    bit            steady_flow;
    int            error_count;
    int            n_ops, n_adds, n_removes, n_tests, n_hits, n_drops, peak_count;

    small_integer_set_table #(
        .SET_CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),    // [31:0] value (signed)
        .s_tuser (s_tuser),    // [1:0] kind
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)     // [0] was_present, [5:1] entry_count, [6] full_drop, [7] zero
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // Applies one operation to the shadow set and returns what the block must report.
    task automatic apply_set_op(input logic [1:0] kind, input logic [31:0] value,
                                output set_result_t res);
        int  slot;
        bit  present;
        bit  dropped;
        slot    = set_count;
        dropped = 1'b0;
        for (int i = 0; i < set_count; i++) begin
            if (slot == set_count && set_store[i] == value)
                slot = i;
        end
        present = (slot < set_count);
        if (kind == KIND_ADD) begin
            n_adds++;
            if (!present) begin
                if (set_count >= CAPACITY) begin
                    dropped = 1'b1;
                    n_drops++;
                end else begin
                    set_store[set_count] = value;
                    set_count++;
                end
            end
        end else if (kind == KIND_REMOVE) begin
            n_removes++;
            if (present) begin
                // The last held entry fills the hole left by the removed one.
                set_store[slot] = set_store[set_count-1];
                set_count--;
            end
        end else begin
            n_tests++;
        end
        n_ops++;
        if (present)
            n_hits++;
        if (set_count > peak_count)
            peak_count = set_count;
        res.was_present = present;
        res.entry_count = set_count[4:0];
        res.full_drop   = dropped;
    endtask

    task automatic send_op(input logic [1:0] kind, input logic [31:0] value);
        int          gap;
        set_result_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        apply_set_op(kind, value, want);
        pending_results.push_back(want);
    endtask

    // Stops sending and waits for every owed result.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_basic_ops();
        send_op(KIND_ADD, 32'h8000_0000);
        send_op(KIND_ADD, 32'h7FFF_FFFF);
        send_op(KIND_ADD, 32'h0000_0000);
        send_op(KIND_ADD, 32'hFFFF_FFFF);
        send_op(KIND_TEST, 32'h8000_0000);
        send_op(KIND_UNUSED, 32'h7FFF_FFFF);
        send_op(KIND_UNUSED, 32'h0000_0005);
        send_op(KIND_ADD, 32'h7FFF_FFFF);
        send_op(KIND_REMOVE, 32'h0000_0005);
        send_op(KIND_REMOVE, 32'h8000_0000);
        send_op(KIND_TEST, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_store();
        int i;
        i = 0;
        while (set_count < CAPACITY) begin
            send_op(KIND_ADD, 32'h0000_0100 + i);
            i++;
        end
        send_op(KIND_ADD, 32'h5555_AAAA);
        send_op(KIND_ADD, 32'h7FFF_FFFF);
        send_op(KIND_REMOVE, 32'h0000_0100);
        send_op(KIND_ADD, 32'hAAAA_5555);
    endtask

    task automatic refill_pool(input int size);
        pool_size = size;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < size; i++)
            value_pool[i] = (i % 3 == 0) ? $urandom_range(0, 63) : $urandom;
    endtask

    task automatic test_random_phase(input int n_items, input int size, input int add_pct,
                                     input int remove_pct, input bit steady);
        int          r;
        logic [1:0]  kind;
        logic [31:0] value;
        refill_pool(size);
        steady_flow = steady;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                kind = KIND_ADD;
            else if (r < add_pct + remove_pct)
                kind = KIND_REMOVE;
            else if (r < 95)
                kind = KIND_TEST;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 9) == 0)
                value = $urandom;
            else
                value = value_pool[$urandom_range(0, pool_size - 1)];
            send_op(kind, value);
        end
        wait_all_results();
        steady_flow = 1'b0;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result transfer, expected none actual %h",
                             $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.was_present)
                    report_field("was_present", want.was_present, m_tdata[0]);
                if (m_tdata[5:1] !== want.entry_count)
                    report_field("entry_count", want.entry_count, m_tdata[5:1]);
                if (m_tdata[6] !== want.full_drop)
                    report_field("full_drop", want.full_drop, m_tdata[6]);
                if (m_tdata[7] !== 1'b0)
                    report_field("padding bit", 0, m_tdata[7]);
            end
        end
    end

    // Result side: ready is mostly high with random stalls, none while flow is steady.
    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0 && !steady_flow) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready   <= 1'b1;
                stall_left = 0;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        set_count   = 0;
        steady_flow = 1'b0;
        error_count = 0;
        n_ops = 0; n_adds = 0; n_removes = 0; n_tests = 0;
        n_hits = 0; n_drops = 0; peak_count = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_full_store();
        wait_all_results();
        test_random_phase(150, 20, 60, 25, 1'b1);
        test_random_phase(150, 12, 40, 35, 1'b0);
        test_random_phase(200, 30, 65, 15, 1'b0);
        test_random_phase(100,  8, 25, 55, 1'b0);
        test_random_phase(100, 24, 45, 30, 1'b1);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d operations: %0d adds, %0d removes, %0d tests or unused codes.",
                 n_ops, n_adds, n_removes, n_tests);
        $display("Values found present %0d times, %0d adds dropped on a full set, peak size %0d.",
                 n_hits, n_drops, peak_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
